/* rtl/core/lasm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_pkg
// Shared types and constants for the local alignment score matrix block.
// ----------------------------------------------------------------------------
package lasm_pkg;
	localparam int MaxLen   = 64;
	localparam int MaxHits  = 64;
	localparam int LenW     = 7;
	localparam int IdxW     = 6;
	localparam int CellW    = 14;
	localparam int CellMax  = 16383;
	localparam int Dim      = MaxLen + 1;
	localparam int MatDepth = Dim * Dim;
	localparam int MatAw    = 13;
	localparam int HitW     = 7;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL_RD,
		ST_FILL_WAIT,
		ST_FILL_WR,
		ST_SCAN_RD,
		ST_SCAN_WAIT,
		ST_SCAN_CHK,
		ST_WALK_RD,
		ST_WALK_WAIT,
		ST_WALK_CHK,
		ST_EMIT,
		ST_EMIT_ZERO,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [CellW-1:0] score;
		logic [LenW-1:0]  row_end;
		logic [LenW-1:0]  col_end;
		logic [LenW-1:0]  run_length;
		logic             last;
		logic             dropped;
	} result_t;
endpackage

/* rtl/core/lasm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lasm_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/core/lasm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_cell
// Recurrence for one matrix cell: max of zero, left, up and diagonal terms.
// ----------------------------------------------------------------------------
module lasm_cell (
	input  logic [lasm_pkg::CellW-1:0] left,
	input  logic [lasm_pkg::CellW-1:0] up,
	input  logic [lasm_pkg::CellW-1:0] diag,
	input  logic                       same,
	input  logic [7:0]                 match_score,
	input  logic signed [10:0]         mismatch_score,
	input  logic signed [10:0]         gap_score,
	output logic [lasm_pkg::CellW-1:0] cell_val
);
	logic signed [16:0] l_v, u_v, d_v, best;

	always_comb begin
		l_v = $signed({3'b0, left}) + 17'(gap_score);
		u_v = $signed({3'b0, up}) + 17'(gap_score);
		d_v = $signed({3'b0, diag}) +
			(same ? $signed({9'b0, match_score}) : 17'(mismatch_score));
		best = '0;
		if (l_v > best) best = l_v;
		if (u_v > best) best = u_v;
		if (d_v > best) best = d_v;
		if (best > 17'sd16383) begin
			cell_val = lasm_pkg::CellW'(lasm_pkg::CellMax);
		end else begin
			cell_val = best[lasm_pkg::CellW-1:0];
		end
	end
endmodule

/* rtl/core/local_alignment_score_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_score_matrix
// Smith-Waterman local alignment over two loaded byte sequences.
// ----------------------------------------------------------------------------
// Load words (cmd 0/1) give no result. A run word fills the score matrix
// held in one 4225 x 14 single-port RAM: row 0 and column 0 are cleared
// first, then each cell costs three reads, a wait and one write. Then every
// cell is scanned with a read, a wait and a check; a maximum cell adds a
// read, a wait and a check per cell on its diagonal walk, the zero cell
// that ends it included, plus an emit state to hand the hit over. No new
// word is accepted until the last result of the run has been taken.
module local_alignment_score_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [1:0] cmd, [9:2] symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [13:0] score, [20:14] row_end,
	                              // [27:21] col_end, [34:28] run_length
	output logic        m_tlast,
	output logic        m_tuser   // dropped
);
	localparam int CW = lasm_pkg::CellW;
	localparam int LW = lasm_pkg::LenW;

	logic [7:0]         match_q;
	logic signed [10:0] mism_q, gap_q;
	logic [LW-1:0]      len_a_q, len_b_q;
	logic [CW-1:0]      best_q;
	lasm_pkg::state_t   state_q, state_d;
	logic [LW-1:0]      i_q, j_q, wi_q, wj_q, n_q;
	logic [1:0]         ph_q;
	logic [CW-1:0]      left_q, up_q, diag_q;
	logic [lasm_pkg::HitW-1:0] hits_q;
	logic               more_q;
	lasm_pkg::result_t  res_q;
	logic               out_v_q;
	logic               init_q;

	logic [1:0] cmd;
	logic [7:0] sym;
	assign cmd = s_tdata[1:0];
	assign sym = s_tdata[9:2];

	logic accept;
	assign accept = s_tvalid && s_tready;

	// sequence stores
	logic a_we, b_we;
	logic [7:0] a_rd, b_rd;
	logic [lasm_pkg::IdxW-1:0] a_addr, b_addr;
	logic [LW-1:0] ia, jb;
	assign a_we = accept && cmd == lasm_pkg::CMD_LOAD_A && len_a_q < LW'(lasm_pkg::MaxLen);
	assign b_we = accept && cmd == lasm_pkg::CMD_LOAD_B && len_b_q < LW'(lasm_pkg::MaxLen);
	assign ia = i_q - 1'b1;
	assign jb = j_q - 1'b1;
	assign a_addr = a_we ? len_a_q[lasm_pkg::IdxW-1:0] : ia[lasm_pkg::IdxW-1:0];
	assign b_addr = b_we ? len_b_q[lasm_pkg::IdxW-1:0] : jb[lasm_pkg::IdxW-1:0];

	lasm_ram #(.Width(8), .Depth(lasm_pkg::MaxLen)) u_seq_a (
		.clk(clk), .we(a_we), .addr(a_addr), .wdata(sym), .rdata(a_rd));
	lasm_ram #(.Width(8), .Depth(lasm_pkg::MaxLen)) u_seq_b (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(sym), .rdata(b_rd));

	// score matrix
	logic m_we;
	logic [lasm_pkg::MatAw-1:0] m_addr;
	logic [CW-1:0] m_wdata, m_rd, cell_val;

	function automatic logic [lasm_pkg::MatAw-1:0] maddr(logic [LW-1:0] r, logic [LW-1:0] c);
		return lasm_pkg::MatAw'(r * lasm_pkg::Dim + c);
	endfunction

	lasm_ram #(.Width(CW), .Depth(lasm_pkg::MatDepth)) u_mat (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rd));

	lasm_cell u_cell (
		.left(left_q), .up(up_q), .diag(diag_q), .same(a_rd == b_rd),
		.match_score(match_q), .mismatch_score(mism_q), .gap_score(gap_q),
		.cell_val(cell_val));

	// init pass (init_q set) writes row 0 (i_q==0), then column 0
	always_comb begin
		m_we = 1'b0;
		m_wdata = '0;
		m_addr = maddr(i_q, j_q);
		unique case (state_q)
			lasm_pkg::ST_FILL_RD: begin
				if (init_q) begin
					m_we = 1'b1;
				end else begin
					unique case (ph_q)
						2'd0: m_addr = maddr(i_q, jb);
						2'd1: m_addr = maddr(ia, j_q);
						default: m_addr = maddr(ia, jb);
					endcase
				end
			end
			lasm_pkg::ST_FILL_WR: begin
				m_we = 1'b1;
				m_wdata = cell_val;
			end
			// address held through the wait so the check sees the walked cell
			lasm_pkg::ST_WALK_RD, lasm_pkg::ST_WALK_WAIT: m_addr = maddr(wi_q, wj_q);
			default: m_addr = maddr(i_q, j_q);
		endcase
	end

	logic fill_done, scan_last_cell;
	assign scan_last_cell = (j_q >= len_b_q) && (i_q >= len_a_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lasm_pkg::ST_IDLE:
				if (accept && cmd == lasm_pkg::CMD_RUN) state_d = lasm_pkg::ST_FILL_RD;
			lasm_pkg::ST_FILL_RD:
				if (!init_q && ph_q == 2'd2) state_d = lasm_pkg::ST_FILL_WAIT;
				else if (init_q && fill_done) begin
					state_d = (len_a_q == '0 || len_b_q == '0)
						? lasm_pkg::ST_EMIT_ZERO : lasm_pkg::ST_FILL_RD;
				end
			lasm_pkg::ST_FILL_WAIT: state_d = lasm_pkg::ST_FILL_WR;
			lasm_pkg::ST_FILL_WR:
				if (j_q == len_b_q && i_q == len_a_q) begin
					state_d = (best_q == '0 && cell_val == '0)
						? lasm_pkg::ST_EMIT_ZERO : lasm_pkg::ST_SCAN_RD;
				end else state_d = lasm_pkg::ST_FILL_RD;
			lasm_pkg::ST_SCAN_RD: state_d = lasm_pkg::ST_SCAN_WAIT;
			lasm_pkg::ST_SCAN_WAIT: state_d = lasm_pkg::ST_SCAN_CHK;
			lasm_pkg::ST_SCAN_CHK:
				if (m_rd == best_q && hits_q < lasm_pkg::HitW'(lasm_pkg::MaxHits))
					state_d = lasm_pkg::ST_WALK_RD;
				else if (scan_last_cell) state_d = lasm_pkg::ST_HOLD;
				else state_d = lasm_pkg::ST_SCAN_RD;
			lasm_pkg::ST_WALK_RD: state_d = lasm_pkg::ST_WALK_WAIT;
			lasm_pkg::ST_WALK_WAIT: state_d = lasm_pkg::ST_WALK_CHK;
			lasm_pkg::ST_WALK_CHK:
				if (wi_q == '0 || wj_q == '0 || m_rd == '0) state_d = lasm_pkg::ST_EMIT;
				else state_d = lasm_pkg::ST_WALK_RD;
			lasm_pkg::ST_EMIT:
				if (!out_v_q) state_d = scan_last_cell ? lasm_pkg::ST_HOLD
					: lasm_pkg::ST_SCAN_RD;
			lasm_pkg::ST_EMIT_ZERO: if (!out_v_q) state_d = lasm_pkg::ST_IDLE;
			lasm_pkg::ST_HOLD: if (!out_v_q) state_d = lasm_pkg::ST_IDLE;
			default: state_d = lasm_pkg::ST_IDLE;
		endcase
	end

	// init walks j_q over 0..len_b (row 0) then column 0 rows 1..len_a
	assign fill_done = (i_q == '0) ? (j_q == len_b_q && len_a_q == '0)
		: (i_q == len_a_q);

	assign s_tready = state_q == lasm_pkg::ST_IDLE && !out_v_q;

	// held result: emitted when the next one shows up or at end of run
	lasm_pkg::result_t pend_q;
	logic pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lasm_pkg::ST_IDLE;
			match_q <= 8'd1;
			mism_q <= -11'sd50;
			gap_q <= -11'sd100;
			len_a_q <= '0;
			len_b_q <= '0;
			best_q <= '0;
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			init_q <= 1'b0;
			ph_q <= '0;
			i_q <= '0;
			j_q <= '0;
			hits_q <= '0;
			more_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					lasm_pkg::REG_MATCH: match_q <= cfg_data[7:0];
					lasm_pkg::REG_MISMATCH: mism_q <= cfg_data;
					lasm_pkg::REG_GAP: gap_q <= cfg_data;
					default: ;
				endcase
			end
			if (a_we) len_a_q <= len_a_q + 1'b1;
			if (b_we) len_b_q <= len_b_q + 1'b1;
			if (out_v_q && m_tready) out_v_q <= 1'b0;

			unique case (state_q)
				lasm_pkg::ST_IDLE: if (accept && cmd == lasm_pkg::CMD_RUN) begin
					init_q <= 1'b1;
					i_q <= '0;
					j_q <= '0;
					best_q <= '0;
					hits_q <= '0;
					more_q <= 1'b0;
					pend_v_q <= 1'b0;
					ph_q <= '0;
				end
				lasm_pkg::ST_FILL_RD: begin
					if (init_q) begin
						if (fill_done) begin
							init_q <= 1'b0;
							i_q <= LW'(1);
							j_q <= LW'(1);
						end else if (i_q == '0 && j_q != len_b_q) j_q <= j_q + 1'b1;
						else begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
						if (ph_q == 2'd1) left_q <= m_rd;
						if (ph_q == 2'd2) up_q <= m_rd;
					end
				end
				lasm_pkg::ST_FILL_WAIT: diag_q <= m_rd;
				lasm_pkg::ST_FILL_WR: begin
					ph_q <= '0;
					if (cell_val > best_q) best_q <= cell_val;
					if (j_q == len_b_q) begin
						j_q <= LW'(1);
						if (i_q == len_a_q) i_q <= LW'(1);
						else i_q <= i_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				lasm_pkg::ST_SCAN_CHK: begin
					if (m_rd == best_q) begin
						if (hits_q < lasm_pkg::HitW'(lasm_pkg::MaxHits)) begin
							hits_q <= hits_q + 1'b1;
							wi_q <= i_q;
							wj_q <= j_q;
							n_q <= '0;
						end else more_q <= 1'b1;
					end
					if (!(m_rd == best_q && hits_q < lasm_pkg::HitW'(lasm_pkg::MaxHits))
					    && !scan_last_cell) begin
						if (j_q == len_b_q) begin
							j_q <= LW'(1);
							i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				lasm_pkg::ST_WALK_CHK: begin
					if (!(wi_q == '0 || wj_q == '0 || m_rd == '0)) begin
						wi_q <= wi_q - 1'b1;
						wj_q <= wj_q - 1'b1;
						n_q <= n_q + 1'b1;
					end
				end
				lasm_pkg::ST_EMIT: if (!out_v_q) begin
					if (pend_v_q) begin
						res_q <= pend_q;
						out_v_q <= 1'b1;
					end
					pend_q <= '{score: best_q, row_end: i_q, col_end: j_q,
						run_length: n_q, last: 1'b0, dropped: 1'b0};
					pend_v_q <= 1'b1;
					if (!scan_last_cell) begin
						if (j_q == len_b_q) begin
							j_q <= LW'(1);
							i_q <= i_q + 1'b1;
						end else j_q <= j_q + 1'b1;
					end
				end
				lasm_pkg::ST_EMIT_ZERO: if (!out_v_q) begin
					res_q <= '{score: '0, row_end: '0, col_end: '0, run_length: '0,
						last: 1'b1, dropped: 1'b0};
					out_v_q <= 1'b1;
					len_a_q <= '0;
					len_b_q <= '0;
					init_q <= 1'b0;
				end
				lasm_pkg::ST_HOLD: if (!out_v_q) begin
					res_q <= '{score: pend_q.score, row_end: pend_q.row_end,
						col_end: pend_q.col_end, run_length: pend_q.run_length,
						last: 1'b1, dropped: more_q};
					out_v_q <= 1'b1;
					pend_v_q <= 1'b0;
					len_a_q <= '0;
					len_b_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'b0, res_q.run_length, res_q.col_end, res_q.row_end, res_q.score};
	assign m_tlast = res_q.last;
	assign m_tuser = res_q.dropped;

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lasm_pkg::ST_IDLE |-> !s_tready) else $error("ready while busy");
	a_drop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast) else $error("dropped without last");
	a_hits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= lasm_pkg::HitW'(lasm_pkg::MaxHits)) else $error("hit count overrun");
endmodule
